// File: src/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared widths and types for the 3x3 Q16.16 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package mi3_pkg;

   // element and intermediate widths
   localparam int ElemW = 32;   // Q16.16 element
   localparam int ProdW = 64;   // element times element
   localparam int CofW  = 65;   // signed 2x2 cofactor
   localparam int PartW = 65;   // cofactor half times element
   localparam int SumW  = 67;   // sum of three partial products
   localparam int DetW  = 99;   // signed determinant
   localparam int DmagW = 98;   // determinant magnitude
   localparam int EmagW = 64;   // cofactor magnitude
   localparam int RemW  = 98;   // divider remainder
   localparam int QuoW  = 32;   // quotient bits after the range check

   // pipeline depths
   localparam int CofLat  = 3;
   localparam int DetLat  = 3;
   localparam int PrepLat = 1;
   localparam int LaneLat = QuoW + 2;
   localparam int TotLat  = CofLat + DetLat + PrepLat + LaneLat;

   // saturation limits
   localparam logic [ElemW-1:0] SatPos = 32'h7FFF_FFFF;
   localparam logic [ElemW-1:0] SatNeg = 32'h8000_0000;

   typedef logic signed [ElemW-1:0] elem_type;
   typedef logic signed [ProdW-1:0] prod_type;
   typedef logic signed [CofW-1:0]  cof_type;
   typedef logic signed [PartW-1:0] part_type;
   typedef logic signed [SumW-1:0]  sum_type;
   typedef logic signed [DetW-1:0]  det_type;
   typedef logic [DmagW-1:0]        dmag_type;
   typedef logic [EmagW-1:0]        emag_type;
   typedef logic [RemW-1:0]         rem_type;
   typedef logic [QuoW-1:0]         quo_type;

endpackage

// File: src/mi3_cofactor.sv
// ----------------------------------------------------------------------------
// mi3_cofactor
// Three-stage pipeline: input register, 2x2 products, signed cofactors.
// ----------------------------------------------------------------------------
module mi3_cofactor (
   input  logic                clock,
   input  mi3_pkg::elem_type   mat [9],
   output mi3_pkg::cof_type    cof [9],
   output mi3_pkg::elem_type   row0 [3]
);

   mi3_pkg::elem_type a_ff [9];
   mi3_pkg::prod_type prod_a_in [9];
   mi3_pkg::prod_type prod_b_in [9];
   mi3_pkg::prod_type prod_a_ff [9];
   mi3_pkg::prod_type prod_b_ff [9];
   mi3_pkg::cof_type  cof_in [9];
   mi3_pkg::cof_type  cof_ff [9];
   mi3_pkg::elem_type row0_d1_ff [3];
   mi3_pkg::elem_type row0_d2_ff [3];

   // minor products and signed cofactor per entry
   for (genvar k = 0; k < 9; k++) begin : g_cof
      localparam int R  = k / 3;
      localparam int C  = k % 3;
      localparam int R1 = (R == 0) ? 1 : 0;
      localparam int R2 = (R == 2) ? 1 : 2;
      localparam int C1 = (C == 0) ? 1 : 0;
      localparam int C2 = (C == 2) ? 1 : 2;
      localparam bit Flip = ((R + C) % 2) == 1;

      logic signed [mi3_pkg::CofW-1:0] minor;

      assign prod_a_in[k] = a_ff[R1*3+C1] * a_ff[R2*3+C2];
      assign prod_b_in[k] = a_ff[R1*3+C2] * a_ff[R2*3+C1];
      assign minor = mi3_pkg::cof_type'(prod_a_ff[k]) - mi3_pkg::cof_type'(prod_b_ff[k]);
      assign cof_in[k] = Flip ? -minor : minor;
   end

   // pipeline registers
   always_ff @(posedge clock) begin
      a_ff       <= mat;
      prod_a_ff  <= prod_a_in;
      prod_b_ff  <= prod_b_in;
      cof_ff     <= cof_in;
      row0_d1_ff <= a_ff[0:2];
      row0_d2_ff <= row0_d1_ff;
   end

   assign cof  = cof_ff;
   assign row0 = row0_d2_ff;

endmodule

// File: src/mi3_det.sv
// ----------------------------------------------------------------------------
// mi3_det
// Three-stage determinant: split partial products, partial sums, final add.
// ----------------------------------------------------------------------------
module mi3_det (
   input  logic                clock,
   input  mi3_pkg::cof_type    cof [9],
   input  mi3_pkg::elem_type   row0 [3],
   output mi3_pkg::det_type    det,
   output mi3_pkg::cof_type    cof_out [9]
);

   mi3_pkg::part_type pl_in [3];
   mi3_pkg::part_type ph_in [3];
   mi3_pkg::part_type pl_ff [3];
   mi3_pkg::part_type ph_ff [3];
   mi3_pkg::sum_type  lo_sum_in;
   mi3_pkg::sum_type  hi_sum_in;
   mi3_pkg::sum_type  lo_sum_ff;
   mi3_pkg::sum_type  hi_sum_ff;
   mi3_pkg::det_type  det_in;
   mi3_pkg::det_type  det_ff;
   mi3_pkg::cof_type  cof_d1_ff [9];
   mi3_pkg::cof_type  cof_d2_ff [9];
   mi3_pkg::cof_type  cof_d3_ff [9];

   // cofactor split into unsigned low half and signed high half
   for (genvar j = 0; j < 3; j++) begin : g_part
      assign pl_in[j] = $signed({1'b0, cof[j][31:0]}) * row0[j];
      assign ph_in[j] = $signed(cof[j][mi3_pkg::CofW-1:32]) * row0[j];
   end

   // partial sums of low and high halves
   assign lo_sum_in = mi3_pkg::sum_type'(pl_ff[0]) + mi3_pkg::sum_type'(pl_ff[1])
                    + mi3_pkg::sum_type'(pl_ff[2]);
   assign hi_sum_in = mi3_pkg::sum_type'(ph_ff[0]) + mi3_pkg::sum_type'(ph_ff[1])
                    + mi3_pkg::sum_type'(ph_ff[2]);

   // recombine halves
   assign det_in = (mi3_pkg::det_type'(hi_sum_ff) <<< 32) + mi3_pkg::det_type'(lo_sum_ff);

   always_ff @(posedge clock) begin
      pl_ff     <= pl_in;
      ph_ff     <= ph_in;
      lo_sum_ff <= lo_sum_in;
      hi_sum_ff <= hi_sum_in;
      det_ff    <= det_in;
      cof_d1_ff <= cof;
      cof_d2_ff <= cof_d1_ff;
      cof_d3_ff <= cof_d2_ff;
   end

   assign det     = det_ff;
   assign cof_out = cof_d3_ff;

endmodule

// File: src/mi3_div_lane.sv
// ----------------------------------------------------------------------------
// mi3_div_lane
// One output element: range check, 32-stage restoring divide, saturation.
// ----------------------------------------------------------------------------
module mi3_div_lane (
   input  logic                clock,
   input  mi3_pkg::cof_type    cof,
   input  mi3_pkg::dmag_type   dmag,
   input  logic                det_neg,
   input  logic                zero,
   output mi3_pkg::elem_type   value,
   output logic                ovf
);

   localparam int Steps = mi3_pkg::QuoW;

   // prep stage
   mi3_pkg::emag_type emag;
   logic              pre_in;

   // divider stages, index 0 is the prep register
   mi3_pkg::rem_type  rem_ff  [Steps+1];
   mi3_pkg::quo_type  q_ff    [Steps+1];
   mi3_pkg::dmag_type dmag_ff [Steps+1];
   logic              neg_ff  [Steps+1];
   logic              pre_ff  [Steps+1];
   logic              zero_ff [Steps+1];

   // output stage
   mi3_pkg::elem_type value_in;
   mi3_pkg::elem_type value_ff;
   logic              ovf_in;
   logic              ovf_ff;

   // magnitude and quotient range check (quotient at least 2^32)
   assign emag   = cof[mi3_pkg::CofW-1] ? mi3_pkg::EmagW'(-cof) : mi3_pkg::EmagW'(cof);
   assign pre_in = mi3_pkg::dmag_type'(emag) >= dmag;

   always_ff @(posedge clock) begin
      rem_ff[0]  <= mi3_pkg::rem_type'(emag);
      q_ff[0]    <= '0;
      dmag_ff[0] <= dmag;
      neg_ff[0]  <= cof[mi3_pkg::CofW-1] ^ det_neg;
      pre_ff[0]  <= pre_in;
      zero_ff[0] <= zero;
   end

   // one quotient bit per stage
   for (genvar s = 0; s < Steps; s++) begin : g_step
      mi3_pkg::rem_type sh;
      logic             ge;

      assign sh = {rem_ff[s][mi3_pkg::RemW-2:0], 1'b0};
      assign ge = sh >= dmag_ff[s];

      always_ff @(posedge clock) begin
         rem_ff[s+1]  <= ge ? sh - dmag_ff[s] : sh;
         q_ff[s+1]    <= {q_ff[s][mi3_pkg::QuoW-2:0], ge};
         dmag_ff[s+1] <= dmag_ff[s];
         neg_ff[s+1]  <= neg_ff[s];
         pre_ff[s+1]  <= pre_ff[s];
         zero_ff[s+1] <= zero_ff[s];
      end
   end

   // sign and saturation
   always_comb begin
      value_in = '0;
      ovf_in   = 1'b0;
      priority if (zero_ff[Steps]) begin
         value_in = '0;
         ovf_in   = 1'b0;
      end else if (!neg_ff[Steps]) begin
         if (pre_ff[Steps] || q_ff[Steps] > mi3_pkg::SatPos) begin
            value_in = mi3_pkg::SatPos;
            ovf_in   = 1'b1;
         end else begin
            value_in = q_ff[Steps];
         end
      end else begin
         if (pre_ff[Steps] || q_ff[Steps] > mi3_pkg::SatNeg) begin
            value_in = mi3_pkg::SatNeg;
            ovf_in   = 1'b1;
         end else begin
            value_in = -q_ff[Steps];
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      ovf_ff   <= ovf_in;
   end

   assign value = value_ff;
   assign ovf   = ovf_ff;

endmodule

// File: src/matrix3_inverse_core.sv
// ----------------------------------------------------------------------------
// matrix3_inverse_core
// Inverse of a 3x3 signed Q16.16 matrix by adjugate over determinant.
// ----------------------------------------------------------------------------
// A request is taken on every cycle that start is high; busy stays low, so
// a new matrix may follow in the very next cycle. Each result appears for
// one cycle, with rsp_valid high, in request order. A request passes three
// cofactor stages, three determinant stages and one determinant magnitude
// stage, then a range-check stage, the 32-stage restoring divider, one
// quotient bit per stage, and a saturation stage.
// The result cannot be held off.
module matrix3_inverse_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  mi3_pkg::elem_type  req_in_r0c0,
   input  mi3_pkg::elem_type  req_in_r0c1,
   input  mi3_pkg::elem_type  req_in_r0c2,
   input  mi3_pkg::elem_type  req_in_r1c0,
   input  mi3_pkg::elem_type  req_in_r1c1,
   input  mi3_pkg::elem_type  req_in_r1c2,
   input  mi3_pkg::elem_type  req_in_r2c0,
   input  mi3_pkg::elem_type  req_in_r2c1,
   input  mi3_pkg::elem_type  req_in_r2c2,
   output logic               rsp_valid,
   output mi3_pkg::elem_type  rsp_out_r0c0,
   output mi3_pkg::elem_type  rsp_out_r0c1,
   output mi3_pkg::elem_type  rsp_out_r0c2,
   output mi3_pkg::elem_type  rsp_out_r1c0,
   output mi3_pkg::elem_type  rsp_out_r1c1,
   output mi3_pkg::elem_type  rsp_out_r1c2,
   output mi3_pkg::elem_type  rsp_out_r2c0,
   output mi3_pkg::elem_type  rsp_out_r2c1,
   output mi3_pkg::elem_type  rsp_out_r2c2,
   output logic               rsp_singular,
   output logic               rsp_overflowed
);

   mi3_pkg::elem_type mat [9];
   mi3_pkg::cof_type  cof [9];
   mi3_pkg::elem_type row0 [3];
   mi3_pkg::det_type  det;
   mi3_pkg::cof_type  cof_d [9];

   // prep stage
   mi3_pkg::dmag_type dmag_ff;
   logic              det_neg_ff;
   logic              sing_in;
   mi3_pkg::cof_type  cof_p_ff [9];

   // valid and singular lines
   logic valid_ff [mi3_pkg::TotLat];
   logic sing_ff  [mi3_pkg::LaneLat+1];

   mi3_pkg::elem_type res [9];
   logic              res_ovf [9];

   assign busy = 1'b0;

   assign mat[0] = req_in_r0c0;
   assign mat[1] = req_in_r0c1;
   assign mat[2] = req_in_r0c2;
   assign mat[3] = req_in_r1c0;
   assign mat[4] = req_in_r1c1;
   assign mat[5] = req_in_r1c2;
   assign mat[6] = req_in_r2c0;
   assign mat[7] = req_in_r2c1;
   assign mat[8] = req_in_r2c2;

   // cofactors
   mi3_cofactor u_cofactor (
      .clock (clock),
      .mat   (mat),
      .cof   (cof),
      .row0  (row0)
   );

   // determinant
   mi3_det u_det (
      .clock   (clock),
      .cof     (cof),
      .row0    (row0),
      .det     (det),
      .cof_out (cof_d)
   );

   // determinant magnitude and singular check
   assign sing_in = det == '0;

   always_ff @(posedge clock) begin
      dmag_ff    <= det[mi3_pkg::DetW-1] ? mi3_pkg::DmagW'(-det) : mi3_pkg::DmagW'(det);
      det_neg_ff <= det[mi3_pkg::DetW-1];
      cof_p_ff   <= cof_d;
      sing_ff[0] <= sing_in;
      for (int i = 1; i <= mi3_pkg::LaneLat; i++) begin
         sing_ff[i] <= sing_ff[i-1];
      end
   end

   // one divider lane per output element, fed the transposed cofactor
   for (genvar k = 0; k < 9; k++) begin : g_lane
      localparam int R = k / 3;
      localparam int C = k % 3;

      mi3_div_lane u_lane (
         .clock   (clock),
         .cof     (cof_p_ff[C*3+R]),
         .dmag    (dmag_ff),
         .det_neg (det_neg_ff),
         .zero    (sing_ff[0]),
         .value   (res[k]),
         .ovf     (res_ovf[k])
      );
   end

   // request valid line
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mi3_pkg::TotLat; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= start;
         for (int i = 1; i < mi3_pkg::TotLat; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   assign rsp_valid      = valid_ff[mi3_pkg::TotLat-1];
   assign rsp_out_r0c0   = res[0];
   assign rsp_out_r0c1   = res[1];
   assign rsp_out_r0c2   = res[2];
   assign rsp_out_r1c0   = res[3];
   assign rsp_out_r1c1   = res[4];
   assign rsp_out_r1c2   = res[5];
   assign rsp_out_r2c0   = res[6];
   assign rsp_out_r2c1   = res[7];
   assign rsp_out_r2c2   = res[8];
   assign rsp_singular   = sing_ff[mi3_pkg::LaneLat];
   assign rsp_overflowed = res_ovf[0] | res_ovf[1] | res_ovf[2] | res_ovf[3] | res_ovf[4]
                         | res_ovf[5] | res_ovf[6] | res_ovf[7] | res_ovf[8];

endmodule
